// ===== hw/rtl/rfc_pkg.sv =====
// Shared types and constants for the disk array redundancy checker.
`default_nettype none

package rfc_pkg;

  // Input field widths
  localparam int unsigned LevelW  = 4;
  localparam int unsigned CountW  = 5;
  localparam int unsigned ActiveW = 16;
  // near_copies * far_copies
  localparam int unsigned CopiesW = 2 * CountW;

  // Array level codes
  localparam logic [LevelW-1:0] LVL_FAULTY    = 4'd0;
  localparam logic [LevelW-1:0] LVL_LINEAR    = 4'd1;
  localparam logic [LevelW-1:0] LVL_MULTIPATH = 4'd2;
  localparam logic [LevelW-1:0] LVL_RAID0     = 4'd3;
  localparam logic [LevelW-1:0] LVL_RAID1     = 4'd4;
  localparam logic [LevelW-1:0] LVL_RAID4     = 4'd5;
  localparam logic [LevelW-1:0] LVL_RAID5     = 4'd6;
  localparam logic [LevelW-1:0] LVL_RAID6     = 4'd7;
  localparam logic [LevelW-1:0] LVL_RAID10    = 4'd8;

  // Missing-member limits for the parity levels
  localparam logic [CountW-1:0] ParityTolerance = 5'd1;
  localparam logic [CountW-1:0] DualTolerance   = 5'd2;

  // Result codes
  typedef enum logic [1:0] {
    ST_HEALTHY  = 2'd0,
    ST_DEGRADED = 2'd1,
    ST_FAILED   = 2'd2
  } array_state_e;

  // Controller to datapath
  typedef struct packed {
    logic load;     // capture the input transfer
    logic setup;    // register the copy count
    logic eval;     // decide simple cases, prime the rotation
    logic step;     // one rotation step
    logic publish;  // move the result into the output register
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic resolved;   // eval found the answer without rotating
    logic loop_done;  // rotation finished this step
  } sts_t;

endpackage

`default_nettype wire

// ===== hw/rtl/rfc_ctrl.sv =====
// Sequencing state machine and output valid flag of the redundancy checker.
`default_nettype none

module rfc_ctrl
  import rfc_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic in_valid_i,
  output logic      in_ready_o,
  output logic      out_valid_o,
  input  wire logic out_ready_i,
  input  wire sts_t sts_i,
  output cmd_t      cmd_o
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SETUP = 3'd1;
  localparam logic [2:0] S_EVAL  = 3'd2;
  localparam logic [2:0] S_LOOP  = 3'd3;
  localparam logic [2:0] S_DONE  = 3'd4;

  logic [2:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;
  logic       slot_free;

  assign slot_free = !out_valid_q || out_ready_i;

  // Next state and commands
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_SETUP;
        end
      end
      S_SETUP: begin
        cmd_o.setup = 1'b1;
        state_d     = S_EVAL;
      end
      S_EVAL: begin
        cmd_o.eval = 1'b1;
        state_d    = sts_i.resolved ? S_DONE : S_LOOP;
      end
      S_LOOP: begin
        cmd_o.step = 1'b1;
        if (sts_i.loop_done) begin
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (slot_free) begin
          cmd_o.publish = 1'b1;
          state_d       = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Output register holds until the sink takes it
  always_comb begin
    if (cmd_o.publish) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;

  // A result is never published over one that is still waiting
  a_no_overwrite : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.publish |-> (!out_valid_q || out_ready_i))
    else $error("result published over a pending one");

  // Every accepted transfer reaches the evaluate step after the setup step
  a_load_to_eval : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load |=> ##1 cmd_o.eval)
    else $error("evaluate step did not follow load");

  // Publishing always raises the output valid
  a_publish_valid : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.publish |=> out_valid_q)
    else $error("published result not presented");

endmodule

`default_nettype wire

// ===== hw/rtl/rfc_dp.sv =====
// Datapath of the redundancy checker: level rules and RAID10 chunk rotation.
`default_nettype none

module rfc_dp
  import rfc_pkg::*;
#(
  parameter int unsigned MAX_DISKS = 16
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire cmd_t                cmd_i,
  output sts_t                     sts_o,
  input  wire logic [LevelW-1:0]   raid_level_i,
  input  wire logic [CountW-1:0]   ideal_devices_i,
  input  wire logic [CountW-1:0]   current_devices_i,
  input  wire logic [CountW-1:0]   near_copies_i,
  input  wire logic [CountW-1:0]   far_copies_i,
  input  wire logic [ActiveW-1:0]  active_mask_i,
  output array_state_e             array_state_o,
  output logic                     config_error_o
);

  localparam int unsigned DW   = MAX_DISKS;
  localparam int unsigned ExtW = (DW > ActiveW) ? DW : ActiveW;

  // Captured transfer
  logic [LevelW-1:0]  level_q;
  logic [CountW-1:0]  ideal_q, cur_q, near_q, far_q;
  logic [ActiveW-1:0] active_q;

  // Rotation state
  logic [CopiesW-1:0] copies_q;
  logic [DW-1:0]      chunk_q, start_q, all_q, fold_q;
  logic [CountW-1:0]  steps_q;

  // Working and output results
  array_state_e res_state_q, out_state_q;
  logic         res_err_q, out_err_q;

  // Derived values
  logic [CountW-1:0] missing;
  logic [CountW:0]   span;
  logic              too_wide;
  logic              copies_ge;
  logic [DW-1:0]     start_mask, all_mask, fold_mask;
  logic [ExtW-1:0]   active_ext;
  logic [DW-1:0]     active_dw;
  logic [DW-1:0]     shifted, chunk_next;
  logic              hit;
  logic [CountW-1:0] steps_next;
  logic              closed;

  array_state_e eval_state;
  logic         eval_err;
  logic         eval_resolved;

  assign missing   = ideal_q - cur_q;
  assign span      = {1'b0, ideal_q} + {1'b0, near_q};
  assign too_wide  = span > (CountW + 1)'(DW);
  assign copies_ge = copies_q >= CopiesW'(DW);

  // Start, disk and fold masks, one comparator per bit
  always_comb begin
    for (int i = 0; i < DW; i++) begin
      start_mask[i] = copies_ge || (copies_q > CopiesW'(i));
      all_mask[i]   = ideal_q > CountW'(i);
      fold_mask[i]  = (ideal_q <= CountW'(i)) && (span > (CountW + 1)'(i));
    end
  end

  assign active_ext = ExtW'(active_q);
  assign active_dw  = active_ext[DW-1:0];

  // Simple level rules and RAID10 early exits
  always_comb begin
    eval_state    = ST_FAILED;
    eval_err      = 1'b0;
    eval_resolved = 1'b1;
    if (cur_q >= ideal_q) begin
      eval_state = ST_HEALTHY;
    end else begin
      case (level_q)
        LVL_FAULTY: eval_state = ST_DEGRADED;
        LVL_LINEAR, LVL_RAID0: eval_state = ST_FAILED;
        LVL_MULTIPATH, LVL_RAID1: begin
          eval_state = (cur_q == '0) ? ST_FAILED : ST_DEGRADED;
        end
        LVL_RAID4, LVL_RAID5: begin
          eval_state = (missing > ParityTolerance) ? ST_FAILED : ST_DEGRADED;
        end
        LVL_RAID6: begin
          eval_state = (missing > DualTolerance) ? ST_FAILED : ST_DEGRADED;
        end
        LVL_RAID10: begin
          if (too_wide) begin
            eval_state = ST_FAILED;
            eval_err   = 1'b1;
          end else if (copies_q == CopiesW'(ideal_q)) begin
            eval_state = (cur_q == '0) ? ST_FAILED : ST_DEGRADED;
          end else if (copies_q == CopiesW'(1)) begin
            eval_state = ST_FAILED;
          end else begin
            eval_resolved = 1'b0;
          end
        end
        default: eval_state = ST_FAILED;
      endcase
    end
  end

  // One rotation step: test, shift by near, fold wrapped bits, cut to disks
  assign hit        = |(active_dw & chunk_q);
  assign shifted    = chunk_q << near_q;
  assign chunk_next = (shifted | ((shifted & fold_q) >> ideal_q)) & all_q;
  assign steps_next = steps_q + CountW'(1);
  assign closed     = (chunk_next == start_q);

  assign sts_o.resolved  = eval_resolved;
  assign sts_o.loop_done = !hit || closed || (steps_next >= ideal_q);

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      level_q  <= raid_level_i;
      ideal_q  <= ideal_devices_i;
      cur_q    <= current_devices_i;
      near_q   <= near_copies_i;
      far_q    <= far_copies_i;
      active_q <= active_mask_i;
    end
    if (cmd_i.setup) begin
      copies_q <= CopiesW'(near_q) * CopiesW'(far_q);
    end
    if (cmd_i.eval) begin
      res_state_q <= eval_state;
      res_err_q   <= eval_err;
      chunk_q     <= start_mask;
      start_q     <= start_mask;
      all_q       <= all_mask;
      fold_q      <= fold_mask;
      steps_q     <= '0;
    end
    if (cmd_i.step) begin
      chunk_q <= chunk_next;
      steps_q <= steps_next;
      if (!hit) begin
        res_state_q <= ST_FAILED;
        res_err_q   <= 1'b0;
      end else if (closed) begin
        res_state_q <= ST_DEGRADED;
        res_err_q   <= 1'b0;
      end else begin
        res_state_q <= ST_FAILED;
        res_err_q   <= 1'b1;
      end
    end
    if (cmd_i.publish) begin
      out_state_q <= res_state_q;
      out_err_q   <= res_err_q;
    end
  end

  assign array_state_o  = out_state_q;
  assign config_error_o = out_err_q;

  // The rotation never runs past the disk count
  a_steps_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.step |-> (steps_q < ideal_q))
    else $error("rotation ran past disk count");

  // Only a degraded RAID10 array reaches the rotation
  a_loop_level : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.step |-> (level_q == LVL_RAID10 && cur_q < ideal_q))
    else $error("rotation entered for a non-RAID10 or healthy array");

  // Rotation starts from its own start mask with a cleared step count
  a_loop_primed : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.eval && !eval_resolved) |=> (chunk_q == start_q && steps_q == '0))
    else $error("rotation not primed");

  // A layout error always comes with a failed state
  a_err_failed : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.publish && res_err_q) |-> (res_state_q == ST_FAILED))
    else $error("layout error without failed state");

endmodule

`default_nettype wire

// ===== hw/rtl/raid_array_failure_check_top.sv =====
// Top level of the disk array redundancy checker.
`default_nettype none

// One transfer in describes a disk array; one transfer out gives its state
// (healthy, degraded, failed) and a layout error flag. Items are handled one
// at a time. Each item passes through the load, setup and evaluate steps
// and, for a RAID10 array that the evaluate step cannot settle, the chunk
// rotation, one shift-fold-test step a cycle. The rotation runs at most
// ideal_devices steps, and an array whose ideal_devices plus near_copies
// exceeds MAX_DISKS fails with a layout error before any rotation, so with
// 16 disks it runs at most 15 steps. The next item is taken the cycle after
// the result is registered, while that result waits in the output
// register; a finished result that cannot move because the previous one is
// still waiting holds the block until the sink takes it.
module raid_array_failure_check_top
  import rfc_pkg::*;
#(
  parameter int unsigned MAX_DISKS = 16
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // raid_level[3:0], ideal_devices[8:4], current_devices[13:9],
  // near_copies[18:14], far_copies[23:19], active_mask[39:24]
  input  wire logic [39:0] s_axis_tdata,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // array_state[1:0], config_error[2], zero[7:3]
  output logic [7:0]       m_axis_tdata,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready
);

  cmd_t         cmd;
  sts_t         sts;
  array_state_e array_state;
  logic         config_error;

  rfc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  rfc_dp #(
    .MAX_DISKS (MAX_DISKS)
  ) u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .sts_o             (sts),
    .raid_level_i      (s_axis_tdata[3:0]),
    .ideal_devices_i   (s_axis_tdata[8:4]),
    .current_devices_i (s_axis_tdata[13:9]),
    .near_copies_i     (s_axis_tdata[18:14]),
    .far_copies_i      (s_axis_tdata[23:19]),
    .active_mask_i     (s_axis_tdata[39:24]),
    .array_state_o     (array_state),
    .config_error_o    (config_error)
  );

  assign m_axis_tdata = {5'b0, config_error, array_state};

endmodule

`default_nettype wire
